FILE: src/waveform_period_duty_measure_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the period/duty meter.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_PERIOD_DUTY_MEASURE_UNIT_ASSERT_SVH
`define WAVEFORM_PERIOD_DUTY_MEASURE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WPDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WPDM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define WPDM_ASSERT(lbl, prop, msg)
`define WPDM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/wpdm_pkg.sv
// ----------------------------------------------------------------------------
// wpdm_pkg
// Widths, constants and shared types of the period/duty meter.
// ----------------------------------------------------------------------------
`default_nettype none
package wpdm_pkg;
  localparam int MAX_SAMPLES = 512;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int RAM_DEPTH   = 2 * MAX_SAMPLES;
  localparam int RAM_AW      = IDX_W + 1;
  localparam int POS_W       = $clog2(10 * MAX_SAMPLES + 1);
  localparam int SPN_W       = 24;
  localparam int PROD_W      = POS_W + SPN_W;
  localparam int DIV_NW      = 48;
  localparam int DIV_DW      = 32;
  localparam int HMUL_W      = CNT_W + 14;
  localparam int JOBQ_DEPTH  = 2;
  localparam int JOBQ_PW     = $clog2(JOBQ_DEPTH);

  localparam logic [SPN_W-1:0]  SPN_RESET    = 24'd1000;
  localparam logic [DIV_DW-1:0] TENTH_NS_US  = 32'd10000;
  localparam logic [DIV_NW-1:0] FREQ_SCALE   = 48'd10000000;
  localparam logic [13:0]       DUTY_SCALE   = 14'd10000;
  localparam logic [9:0]        DUTY_MAX     = 10'd1000;
  localparam logic [7:0]        LEVEL_MAX    = 8'hFF;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [7:0]       min_level;
    logic [7:0]       max_level;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;
endpackage
`default_nettype wire

FILE: src/wpdm_if.sv
// ----------------------------------------------------------------------------
// wpdm channels
// Valid/ready channels for samples in and measurement results out.
// ----------------------------------------------------------------------------
`default_nettype none
interface wpdm_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface wpdm_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  min_level;
  logic [7:0]  max_level;
  logic [31:0] period_us;
  logic [23:0] freq_tenth_hz;
  logic [9:0]  duty_permille;
  logic        measure_valid;
  modport source (output valid, output min_level, output max_level, output period_us,
                  output freq_tenth_hz, output duty_permille, output measure_valid,
                  input ready);
  modport sink (input valid, input min_level, input max_level, input period_us,
                input freq_tenth_hz, input duty_permille, input measure_valid,
                output ready);
endinterface
`default_nettype wire

FILE: src/wpdm_ram.sv
// ----------------------------------------------------------------------------
// wpdm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module wpdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: src/wpdm_jobq.sv
// ----------------------------------------------------------------------------
// wpdm_jobq
// Short FIFO of closed windows between the loader and the analyzer.
// ----------------------------------------------------------------------------
`default_nettype none
module wpdm_jobq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire wpdm_pkg::job_t push_job,
  input  wire logic          pop,
  output wpdm_pkg::job_t     head,
  output logic               full,
  output logic               empty
);
  wpdm_pkg::job_t                  ent [wpdm_pkg::JOBQ_DEPTH];
  logic [wpdm_pkg::JOBQ_PW-1:0]    wp;
  logic [wpdm_pkg::JOBQ_PW-1:0]    rp;
  logic [wpdm_pkg::JOBQ_PW:0]      cnt;

  assign full  = (cnt == (wpdm_pkg::JOBQ_PW + 1)'(wpdm_pkg::JOBQ_DEPTH));
  assign empty = (cnt == '0);
  assign head  = ent[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= wp + 1'b1;
      end
      if (pop && !empty) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (wpdm_pkg::JOBQ_PW + 1)'(push && !full)
                 - (wpdm_pkg::JOBQ_PW + 1)'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

FILE: src/wpdm_front.sv
// ----------------------------------------------------------------------------
// wpdm_front
// Sample loader: stores a window into a free bank, tracks min/max, queues it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "waveform_period_duty_measure_unit_assert.svh"
module wpdm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  wpdm_sample_if.sink                        samples,
  output logic                               ram_we,
  output logic [wpdm_pkg::RAM_AW-1:0]        ram_waddr,
  output logic [7:0]                         ram_wdata,
  output logic                               job_push,
  output wpdm_pkg::job_t                     job,
  input  wire logic                          q_full,
  input  wire wpdm_pkg::release_t            rel
);
  logic                          wbank;
  logic [wpdm_pkg::CNT_W-1:0]    count;
  logic [7:0]                    rmin;
  logic [7:0]                    rmax;
  logic [1:0]                    bank_busy;
  logic                          acc;
  logic                          store;
  logic [7:0]                    min_next;
  logic [7:0]                    max_next;
  logic [wpdm_pkg::CNT_W-1:0]    count_next;

  assign samples.ready = !bank_busy[wbank] && !q_full;
  assign acc   = samples.valid && samples.ready;
  assign store = acc && (count < wpdm_pkg::CNT_W'(wpdm_pkg::MAX_SAMPLES));

  assign min_next   = (store && samples.sample < rmin) ? samples.sample : rmin;
  assign max_next   = (store && samples.sample > rmax) ? samples.sample : rmax;
  assign count_next = store ? count + 1'b1 : count;

  assign ram_we    = store;
  assign ram_waddr = {wbank, count[wpdm_pkg::IDX_W-1:0]};
  assign ram_wdata = samples.sample;

  assign job_push      = acc && samples.last_sample;
  assign job.bank      = wbank;
  assign job.count     = count_next;
  assign job.min_level = min_next;
  assign job.max_level = max_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wbank     <= 1'b0;
      count     <= '0;
      rmin      <= wpdm_pkg::LEVEL_MAX;
      rmax      <= '0;
      bank_busy <= '0;
    end else begin
      if (rel.valid) begin
        bank_busy[rel.bank] <= 1'b0;
      end
      if (job_push) begin
        count            <= '0;
        rmin             <= wpdm_pkg::LEVEL_MAX;
        rmax             <= '0;
        bank_busy[wbank] <= 1'b1;
        wbank            <= !wbank;
      end else begin
        count <= count_next;
        rmin  <= min_next;
        rmax  <= max_next;
      end
    end
  end

  `WPDM_ASSERT(a_push_room, job_push |-> !q_full, "window queued into a full queue")
  `WPDM_ASSERT(a_release_busy, rel.valid |-> bank_busy[rel.bank], "release of a free bank")
  `WPDM_ASSERT(a_window_cleared, job_push |=> (count == '0), "window count not cleared")
endmodule
`default_nettype wire

FILE: src/wpdm_div.sv
// ----------------------------------------------------------------------------
// wpdm_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wpdm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [wpdm_pkg::DIV_NW-1:0]   num,
  input  wire logic [wpdm_pkg::DIV_DW-1:0]   den,
  output logic                               busy,
  output logic                               done,
  output logic [wpdm_pkg::DIV_NW-1:0]        quo
);
  localparam int CW = $clog2(wpdm_pkg::DIV_NW);

  logic [wpdm_pkg::DIV_DW-1:0] rem;
  logic [wpdm_pkg::DIV_DW-1:0] den_r;
  logic [CW-1:0]               cnt;
  logic [wpdm_pkg::DIV_DW:0]   rem_sh;
  logic [wpdm_pkg::DIV_DW:0]   diff;
  logic                        ge;

  assign rem_sh = {rem, quo[wpdm_pkg::DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[wpdm_pkg::DIV_DW-1:0] : rem_sh[wpdm_pkg::DIV_DW-1:0];
      quo <= {quo[wpdm_pkg::DIV_NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(wpdm_pkg::DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/wpdm_back.sv
// ----------------------------------------------------------------------------
// wpdm_back
// Analyzer: scans a stored window for mid-level crossings, then derives period,
// frequency and duty through the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "waveform_period_duty_measure_unit_assert.svh"
module wpdm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wpdm_pkg::job_t                q_head,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  output logic                               ram_re,
  output logic [wpdm_pkg::RAM_AW-1:0]        ram_raddr,
  input  wire logic [7:0]                    ram_rdata,
  output wpdm_pkg::release_t                 rel,
  input  wire logic [wpdm_pkg::SPN_W-1:0]    spn,
  wpdm_result_if.source                      result
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_SH   = 10'b0000000100,
    S_QDIV = 10'b0000001000,
    S_CALC = 10'b0000010000,
    S_MUL  = 10'b0000100000,
    S_D1   = 10'b0001000000,
    S_D2   = 10'b0010000000,
    S_D3   = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  localparam int CW = wpdm_pkg::CNT_W;
  localparam int PW = wpdm_pkg::POS_W;

  state_t                         state;
  logic                           bank;
  logic [CW-1:0]                  n;
  logic [CW-1:0]                  idx;
  logic [CW-1:0]                  rises;
  logic [CW-1:0]                  high;
  logic [CW-1:0]                  last_fall;
  logic [CW-1:0]                  rise_i;
  logic [7:0]                     lmin;
  logic [7:0]                     lmax;
  logic [9:0]                     line3;
  logic [7:0]                     w1;
  logic [7:0]                     w2;
  logic [7:0]                     w3;
  logic                           look_rise;
  logic [PW-1:0]                  first10;
  logic [PW-1:0]                  last10;
  logic [13:0]                    num;
  logic [9:0]                     den;
  logic [3:0]                     qacc;
  logic [1:0]                     qstep;
  logic [wpdm_pkg::PROD_W-1:0]    prod;
  logic [wpdm_pkg::HMUL_W-1:0]    hmul;
  logic [31:0]                    period;
  logic [23:0]                    freq;
  logic [9:0]                     duty;
  logic                           valid;
  logic                           div_go;
  logic [wpdm_pkg::DIV_NW-1:0]    div_num;
  logic [wpdm_pkg::DIV_DW-1:0]    div_den;
  logic                           div_busy;
  logic                           div_done;
  logic [wpdm_pkg::DIV_NW-1:0]    div_quo;
  logic                           out_valid;
  logic                           out_load;

  logic [7:0]                     mid;
  logic [8:0]                     lsum;
  logic [9:0]                     s0;
  logic [9:0]                     s1;
  logic [CW-1:0]                  i_cur;
  logic                           rise_hit;
  logic                           fall_hit;
  logic [13:0]                    dsh;
  logic                           qbit;
  logic [PW-1:0]                  pos_new;
  logic [PW-1:0]                  span;
  logic [CW-1:0]                  h;

  wpdm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign lsum     = {1'b0, q_head.min_level} + {1'b0, q_head.max_level};
  assign mid      = lsum[8:1];
  assign s0       = {2'b0, w1} + {2'b0, w2} + {2'b0, w3};
  assign s1       = {2'b0, w2} + {2'b0, w3} + {2'b0, ram_rdata};
  assign i_cur    = idx - CW'(2);
  assign rise_hit = look_rise && (s0 <= line3) && (s1 > line3);
  assign fall_hit = !look_rise && (s0 > line3) && (s1 <= line3);
  assign dsh      = {4'b0, den} << qstep;
  assign qbit     = num >= dsh;
  assign pos_new  = PW'(rise_i) * PW'(10) + PW'({qacc[3:1], qbit});
  assign span     = last10 - first10;
  assign h        = high - (look_rise ? last_fall : CW'(0));

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign ram_re    = (state == S_RD) && (idx != n);
  assign ram_raddr = {bank, idx[wpdm_pkg::IDX_W-1:0]};
  assign out_load  = (state == S_OUT) && (!out_valid || result.ready);
  assign rel.valid = out_load;
  assign rel.bank  = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      div_go <= 1'b0;
      idx    <= '0;
      n      <= '0;
    end else begin
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            bank      <= q_head.bank;
            n         <= q_head.count;
            lmin      <= q_head.min_level;
            lmax      <= q_head.max_level;
            line3     <= {1'b0, mid, 1'b0} + {2'b0, mid};
            idx       <= '0;
            rises     <= '0;
            high      <= '0;
            last_fall <= '0;
            look_rise <= 1'b1;
            first10   <= '0;
            last10    <= '0;
            period    <= '0;
            freq      <= '0;
            duty      <= '0;
            valid     <= 1'b0;
            state     <= S_RD;
          end
        end
        S_RD: begin
          state <= (idx == n) ? S_CALC : S_SH;
        end
        S_SH: begin
          w1    <= w2;
          w2    <= w3;
          w3    <= ram_rdata;
          idx   <= idx + 1'b1;
          state <= S_RD;
          if (idx >= CW'(3)) begin
            if (rise_hit) begin
              num    <= 14'(line3 - s0) * 14'(10);
              den    <= s1 - s0;
              rise_i <= i_cur;
              qacc   <= '0;
              qstep  <= 2'd3;
              state  <= S_QDIV;
            end else if (fall_hit) begin
              last_fall <= i_cur - rise_i;
              high      <= high + (i_cur - rise_i);
              look_rise <= 1'b1;
            end
          end
        end
        S_QDIV: begin
          if (qbit) begin
            num <= num - dsh;
          end
          qacc[qstep] <= qbit;
          if (qstep == 2'd0) begin
            last10 <= pos_new;
            if (rises == '0) begin
              first10 <= pos_new;
            end
            rises     <= rises + 1'b1;
            look_rise <= 1'b0;
            state     <= S_RD;
          end else begin
            qstep <= qstep - 1'b1;
          end
        end
        S_CALC: begin
          if (rises >= CW'(2) && last10 > first10) begin
            prod  <= wpdm_pkg::PROD_W'(span) * wpdm_pkg::PROD_W'(spn);
            state <= S_MUL;
          end else begin
            state <= S_OUT;
          end
        end
        // floor(floor(a/b)/c) == floor(a/(b*c)): one division gives the period
        S_MUL: begin
          div_go  <= 1'b1;
          div_num <= wpdm_pkg::DIV_NW'(prod);
          div_den <= wpdm_pkg::TENTH_NS_US * wpdm_pkg::DIV_DW'(rises - 1'b1);
          state   <= S_D1;
        end
        S_D1: begin
          if (div_done) begin
            period <= div_quo[31:0];
            if (div_quo == '0) begin
              state <= S_OUT;
            end else begin
              div_go  <= 1'b1;
              div_num <= wpdm_pkg::FREQ_SCALE;
              div_den <= div_quo[wpdm_pkg::DIV_DW-1:0];
              hmul    <= wpdm_pkg::HMUL_W'(h) * wpdm_pkg::HMUL_W'(wpdm_pkg::DUTY_SCALE);
              state   <= S_D2;
            end
          end
        end
        S_D2: begin
          if (div_done) begin
            freq    <= div_quo[23:0];
            div_go  <= 1'b1;
            div_num <= wpdm_pkg::DIV_NW'(hmul);
            div_den <= wpdm_pkg::DIV_DW'(span);
            state   <= S_D3;
          end
        end
        S_D3: begin
          if (div_done) begin
            duty  <= (div_quo > wpdm_pkg::DIV_NW'(wpdm_pkg::DUTY_MAX)) ?
                     wpdm_pkg::DUTY_MAX : div_quo[9:0];
            valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register, frees the analyzer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.min_level     <= lmin;
      result.max_level     <= lmax;
      result.period_us     <= period;
      result.freq_tenth_hz <= freq;
      result.duty_permille <= duty;
      result.measure_valid <= valid;
    end
  end

  assign result.valid = out_valid;

  `WPDM_ASSERT(a_div_free, div_go |-> !div_busy, "divider started while busy")
  `WPDM_ASSERT(a_two_rises, (state == S_D1) |-> (rises >= CW'(2)), "period without two rises")
  `WPDM_ASSERT_NEVER(a_idx_bound, idx > n, "scan ran past the window")
endmodule
`default_nettype wire

FILE: src/waveform_period_duty_measure_unit.sv
// Samples load at 1 per cycle while a free bank exists; a window of n samples
//   is analyzed after its last sample by a scan, then up to three divisions.
// Throughput: 1 sample per cycle while a free bank exists; the analyzer scan
//   (read and shift states) and the 1-bit-per-cycle divider set the pace.
// Reset: synchronous, active high; clears control state, period register = 1000.
// ----------------------------------------------------------------------------
// waveform_period_duty_measure_unit
// Mean-crossing period, frequency and duty meter over windows of samples.
// ----------------------------------------------------------------------------
`default_nettype none
module waveform_period_duty_measure_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [wpdm_pkg::SPN_W-1:0]    cfg_wr_data,
  wpdm_sample_if.sink                        samples,
  wpdm_result_if.source                      results
);
  logic [wpdm_pkg::SPN_W-1:0]     sample_period_ns;
  logic                           ram_we;
  logic [wpdm_pkg::RAM_AW-1:0]    ram_waddr;
  logic [7:0]                     ram_wdata;
  logic                           ram_re;
  logic [wpdm_pkg::RAM_AW-1:0]    ram_raddr;
  logic [7:0]                     ram_rdata;
  logic                           job_push;
  wpdm_pkg::job_t                 job;
  wpdm_pkg::job_t                 q_head;
  logic                           q_full;
  logic                           q_empty;
  logic                           q_pop;
  wpdm_pkg::release_t             rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period_ns <= wpdm_pkg::SPN_RESET;
    end else if (cfg_wr_en) begin
      sample_period_ns <= cfg_wr_data;
    end
  end

  wpdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_push  (job_push),
    .job       (job),
    .q_full    (q_full),
    .rel       (rel)
  );

  wpdm_ram #(
    .WIDTH (8),
    .DEPTH (wpdm_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wpdm_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  wpdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rel       (rel),
    .spn       (sample_period_ns),
    .result    (results)
  );
endmodule
`default_nettype wire

FILE: dv/tb_waveform_period_duty_measure_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_period_duty_measure_unit
// Streams sample windows through the meter and scores every measurement
// against an in-bench model of min/max, mid-level crossings, period, frequency
// and duty. Several sample periods, random idling on both channels, a long
// result backpressure stretch and overfull windows are exercised.
// ----------------------------------------------------------------------------
module tb_waveform_period_duty_measure_unit;
  localparam int WDOG_LIMIT = 20000;
  localparam int SETTLE     = 1500;

  typedef struct {
    logic [7:0] smp;
    logic       lst;
  } smp_item_t;

  typedef struct {
    logic [7:0]  mn;
    logic [7:0]  mx;
    logic [31:0] per;
    logic [23:0] frq;
    logic [9:0]  dty;
    logic        ok;
  } meas_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [wpdm_pkg::SPN_W-1:0] cfg_wr_data = '0;

  wpdm_sample_if smp_ch ();
  wpdm_result_if res_ch ();

  waveform_period_duty_measure_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .samples    (smp_ch),
    .results    (res_ch)
  );

  always #2 clk = ~clk;

  smp_item_t   pend_q[$];
  meas_t       meas_q[$];
  logic [7:0]  win_q[$];
  logic [23:0] period_ns = 24'd1000;
  logic [7:0]  win_min = 8'hFF;
  logic [7:0]  win_max = 8'h00;
  int          errors = 0;
  bit          quiet = 0;
  int          hold_req = 0;
  int          hold_done = 0;
  int          items = 0;
  int          windows = 0;

  initial begin
    smp_ch.valid = 1'b0;
    smp_ch.sample = '0;
    smp_ch.last_sample = 1'b0;
    res_ch.ready = 1'b0;
  end

  function automatic meas_t measure(input logic [7:0] w[$], input logic [7:0] mn,
                                    input logic [7:0] mx, input logic [23:0] pns);
    meas_t r;
    int n, line3, s0, s1;
    longint unsigned first10, last10, high, last_fall, rises, pos, spn, per, h, d;
    bit look_rise;
    n = w.size();
    line3 = 3 * ((int'(mn) + int'(mx)) / 2);
    first10 = 0; last10 = 0; high = 0; last_fall = 0; rises = 0;
    look_rise = 1;
    r.mn = mn; r.mx = mx; r.per = '0; r.frq = '0; r.dty = '0; r.ok = 1'b0;
    for (int i = 1; i + 2 < n; i++) begin
      s0 = int'(w[i-1]) + int'(w[i]) + int'(w[i+1]);
      s1 = int'(w[i]) + int'(w[i+1]) + int'(w[i+2]);
      if (look_rise) begin
        if (s0 <= line3 && s1 > line3) begin
          pos = 10 * longint'(i) + longint'((10 * (line3 - s0)) / (s1 - s0));
          if (rises == 0) first10 = pos;
          last10 = pos;
          rises++;
          look_rise = 0;
        end
      end else if (s0 > line3 && s1 <= line3) begin
        last_fall = longint'(i) - last10 / 10;
        high += last_fall;
        look_rise = 1;
      end
    end
    if (rises >= 2 && last10 > first10) begin
      spn = last10 - first10;
      per = spn * longint'(pns) / 10000 / (rises - 1);
      if (per != 0) begin
        h = high - (look_rise ? last_fall : 0);
        d = 10000 * h / spn;
        if (d > 1000) d = 1000;
        r.per = per[31:0];
        r.frq = 24'(64'd10000000 / per);
        r.dty = d[9:0];
        r.ok = 1'b1;
      end
    end
    return r;
  endfunction

  // sample side transfers feed the window model
  always @(posedge clk) begin
    if (!rst && smp_ch.valid && smp_ch.ready) begin
      if (win_q.size() < wpdm_pkg::MAX_SAMPLES) begin
        win_q.push_back(smp_ch.sample);
        if (smp_ch.sample < win_min) win_min = smp_ch.sample;
        if (smp_ch.sample > win_max) win_max = smp_ch.sample;
      end
      if (smp_ch.last_sample) begin
        meas_q.push_back(measure(win_q, win_min, win_max, period_ns));
        win_q.delete();
        win_min = 8'hFF;
        win_max = 8'h00;
      end
    end
  end

  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      smp_ch.valid <= 1'b0;
    end else if (!(smp_ch.valid && !smp_ch.ready)) begin
      if (gap > 0) begin
        gap--;
        smp_ch.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        smp_item_t it;
        it = pend_q.pop_front();
        smp_ch.sample <= it.smp;
        smp_ch.last_sample <= it.lst;
        smp_ch.valid <= 1'b1;
        if (!quiet && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 18);
      end else begin
        smp_ch.valid <= 1'b0;
      end
    end
  end

  int stall = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_cnt = 400;
      res_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      res_ch.ready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      res_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 18) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (meas_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result min=%0d max=%0d", $realtime,
                 res_ch.min_level, res_ch.max_level);
      end else begin
        meas_t e;
        e = meas_q.pop_front();
        if (res_ch.min_level !== e.mn || res_ch.max_level !== e.mx ||
            res_ch.period_us !== e.per || res_ch.freq_tenth_hz !== e.frq ||
            res_ch.duty_permille !== e.dty || res_ch.measure_valid !== e.ok) begin
          errors++;
          $display("%0t: mismatch exp min=%0d max=%0d per=%0d frq=%0d dty=%0d ok=%0d",
                   $realtime, e.mn, e.mx, e.per, e.frq, e.dty, e.ok);
          $display("%0t:          got min=%0d max=%0d per=%0d frq=%0d dty=%0d ok=%0d",
                   $realtime, res_ch.min_level, res_ch.max_level, res_ch.period_us,
                   res_ch.freq_tenth_hz, res_ch.duty_permille, res_ch.measure_valid);
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WDOG_LIMIT) begin
      $display("tb_waveform_period_duty_measure_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push(input logic [7:0] v, input logic l);
    smp_item_t it;
    it.smp = v;
    it.lst = l;
    pend_q.push_back(it);
    items++;
    if (l) windows++;
  endtask

  task automatic add_window(input int len);
    int kind, lo, hi, per, hw, ph;
    logic [7:0] v;
    kind = $urandom_range(0, 9);
    lo = $urandom_range(0, 127);
    hi = $urandom_range(lo, 255);
    per = $urandom_range(2, 16);
    hw = $urandom_range(0, per);
    ph = $urandom_range(0, per - 1);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: v = 8'($urandom_range(0, 255));
        1: v = 8'(lo);
        2, 3: v = 8'(((i * (hi - lo)) / len + lo));
        default: begin
          v = (((i + ph) % per) < hw) ? 8'(hi) : 8'(lo);
          if ($urandom_range(0, 7) == 0) v = v ^ 8'($urandom_range(0, 3));
        end
      endcase
      push(v, i == len - 1);
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pend_q.size() > 0 || smp_ch.valid || meas_q.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_period(input logic [23:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    period_ns = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input int n_items, input int n_win);
    int t0, w0, len;
    t0 = items;
    w0 = windows;
    while (items - t0 < n_items || windows - w0 < n_win) begin
      if ($urandom_range(0, 150) == 0) len = $urandom_range(505, 520);
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 5);
      else len = $urandom_range(8, 40);
      add_window(len);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_period(24'd1000);

    push(8'd0, 1'b1);
    push(8'd255, 1'b0); push(8'd0, 1'b1);
    push(8'd0, 1'b0); push(8'd255, 1'b0); push(8'd0, 1'b1);
    push(8'd0, 1'b0); push(8'd0, 1'b0); push(8'd255, 1'b0); push(8'd255, 1'b1);
    for (int i = 0; i < 14; i++) push(((i % 4) < 2) ? 8'd0 : 8'd255, i == 13);
    drain();

    set_period(24'hFFFFFF);
    random_phase(200, 8);
    drain();

    set_period(24'd1);
    random_phase(120, 5);
    drain();

    set_period(24'($urandom_range(1, 24'hFFFFFF)));
    hold_req = hold_req + 1;
    for (int k = 0; k < 12; k++) add_window(8);
    random_phase(150, 8);
    drain();

    set_period(24'($urandom_range(100, 5000)));
    random_phase(200, 10);
    drain();

    quiet = 1;
    set_period(24'd1000);
    random_phase(150, 8);
    drain();

    if (errors == 0) begin
      $display("tb_waveform_period_duty_measure_unit: clean");
    end else begin
      $display("tb_waveform_period_duty_measure_unit: errors");
    end
    $finish;
  end
endmodule
